### rtl/min_pair_average_after_sort_core_assert.svh
// ----------------------------------------------------------------------------
// Minimum pair average core: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef MIN_PAIR_AVERAGE_AFTER_SORT_CORE_ASSERT_SVH
`define MIN_PAIR_AVERAGE_AFTER_SORT_CORE_ASSERT_SVH

// Same-cycle implication.
`define MPA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mpa assertion failed");

// Next-cycle implication.
`define MPA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mpa assertion failed");

`endif

### rtl/mpa_pkg.sv
// ----------------------------------------------------------------------------
// Minimum pair average package
// Sizes and the result record shared by the core's files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mpa_pkg;

  localparam int unsigned MaxItems = 256;
  localparam int unsigned AddrW    = $clog2(MaxItems);
  localparam int unsigned CntW     = $clog2(MaxItems + 1);
  localparam int unsigned CountW   = 31;
  localparam int unsigned SumW     = 32;

  // Result handed from the controller to the output register.
  typedef struct packed {
    logic            valid;
    logic [SumW-1:0] sum;
    logic            error;
  } res_t;

endpackage

### rtl/mpa_if.sv
// ----------------------------------------------------------------------------
// Minimum pair average channels
// Valid/ready channels for the count requests and the result requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mpa_in_if;
  logic                         valid;
  logic                         ready;
  logic [mpa_pkg::CountW-1:0]   view_count;
  logic                         last_item;

  modport source (output valid, output view_count, output last_item, input ready);
  modport sink   (input valid, input view_count, input last_item, output ready);
endinterface

interface mpa_out_if;
  logic                       valid;
  logic                       ready;
  logic [mpa_pkg::SumW-1:0]   min_average_halves;
  logic                       error;

  modport source (output valid, output min_average_halves, output error, input ready);
  modport sink   (input valid, input min_average_halves, input error, output ready);
endinterface

### rtl/mpa_ram.sv
// ----------------------------------------------------------------------------
// Minimum pair average RAM
// One write port, two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpa_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 31
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

### rtl/mpa_ctrl.sv
// ----------------------------------------------------------------------------
// Minimum pair average controller
// Sorted insertion into the RAM on load, then a two-port pair scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "min_pair_average_after_sort_core_assert.svh"

module mpa_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mpa_in_if.sink                        in_i,
  output logic                          mem_we_o,
  output logic [mpa_pkg::AddrW-1:0]     mem_waddr_o,
  output logic [mpa_pkg::CountW-1:0]    mem_wdata_o,
  output logic [mpa_pkg::AddrW-1:0]     mem_raddr_a_o,
  output logic [mpa_pkg::AddrW-1:0]     mem_raddr_b_o,
  input  logic [mpa_pkg::CountW-1:0]    mem_rdata_a_i,
  input  logic [mpa_pkg::CountW-1:0]    mem_rdata_b_i,
  output mpa_pkg::res_t                 res_o,
  input  logic                          res_ready_i
);

  localparam int unsigned AddrW    = mpa_pkg::AddrW;
  localparam int unsigned CntW     = mpa_pkg::CntW;
  localparam int unsigned CountW   = mpa_pkg::CountW;
  localparam int unsigned SumW     = mpa_pkg::SumW;
  localparam int unsigned MaxItems = mpa_pkg::MaxItems;

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StShift  = 4'b0010,
    StScan   = 4'b0100,
    StResult = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              ovf_q, ovf_d;
  logic              pend_q, pend_d;
  logic [AddrW-1:0]  j_q, j_d;
  logic [CountW-1:0] key_q, key_d;
  logic              last_q, last_d;
  logic [AddrW-1:0]  lo_q, lo_d;
  logic [AddrW-1:0]  hi_q, hi_d;
  logic [SumW-1:0]   best_q, best_d;
  logic              err_q, err_d;

  logic              fin;
  logic [CntW-1:0]   fin_cnt;
  logic              fin_ovf;
  logic              fin_last;
  logic [SumW-1:0]   pair_sum;

  assign in_i.ready  = (state_q == StIdle);
  assign pair_sum    = SumW'(mem_rdata_a_i) + SumW'(mem_rdata_b_i);
  assign res_o.valid = (state_q == StResult);
  assign res_o.sum   = best_q;
  assign res_o.error = err_q;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    pend_d   = pend_q;
    j_d      = j_q;
    key_d    = key_q;
    last_d   = last_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    best_d   = best_q;
    err_d    = err_q;
    fin      = 1'b0;
    fin_cnt  = cnt_q;
    fin_ovf  = ovf_q;
    fin_last = last_q;

    mem_we_o      = 1'b0;
    mem_waddr_o   = j_q;
    mem_wdata_o   = key_q;
    mem_raddr_a_o = lo_q;
    mem_raddr_b_o = hi_q;

    case (state_q)
      StIdle: begin
        if (in_i.valid) begin
          if (cnt_q < CntW'(MaxItems)) begin
            cnt_d = cnt_q + CntW'(1);
            if (cnt_q == '0) begin
              // First count of a set: nothing to shift past.
              mem_we_o    = 1'b1;
              mem_waddr_o = '0;
              mem_wdata_o = in_i.view_count;
              fin         = 1'b1;
              fin_cnt     = cnt_q + CntW'(1);
              fin_ovf     = ovf_q;
              fin_last    = in_i.last_item;
            end else begin
              // Fetch the current top entry and walk down from there.
              mem_raddr_a_o = AddrW'(cnt_q - CntW'(1));
              j_d           = AddrW'(cnt_q);
              key_d         = in_i.view_count;
              last_d        = in_i.last_item;
              state_d       = StShift;
            end
          end else begin
            // Store full: drop the count and flag it.
            ovf_d    = 1'b1;
            fin      = 1'b1;
            fin_cnt  = cnt_q;
            fin_ovf  = 1'b1;
            fin_last = in_i.last_item;
          end
        end
      end
      StShift: begin
        if (j_q == '0 || mem_rdata_a_i <= key_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = j_q;
          mem_wdata_o = key_q;
          fin         = 1'b1;
        end else begin
          // Move the larger entry up one slot; prefetch the next one down.
          mem_we_o      = 1'b1;
          mem_waddr_o   = j_q;
          mem_wdata_o   = mem_rdata_a_i;
          mem_raddr_a_o = j_q - AddrW'(2);
          j_d           = j_q - AddrW'(1);
        end
      end
      StScan: begin
        if (lo_q < hi_q) begin
          lo_d   = lo_q + AddrW'(1);
          hi_d   = hi_q - AddrW'(1);
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q && pair_sum < best_q) begin
          best_d = pair_sum;
        end
        if (!(lo_q < hi_q) && !pend_q) begin
          err_d   = 1'b0;
          state_d = StResult;
        end
      end
      StResult: begin
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (fin) begin
      state_d = StIdle;
      if (fin_last) begin
        cnt_d = '0;
        ovf_d = 1'b0;
        if (fin_ovf || fin_cnt < CntW'(2)) begin
          err_d   = 1'b1;
          best_d  = '0;
          state_d = StResult;
        end else begin
          lo_d    = '0;
          hi_d    = AddrW'(fin_cnt - CntW'(1));
          best_d  = '1;
          pend_d  = 1'b0;
          state_d = StScan;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q    <= j_d;
    key_q  <= key_d;
    last_q <= last_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    best_q <= best_d;
    err_q  <= err_d;
  end

  `MPA_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CntW'(MaxItems))
  `MPA_ASSERT_IMP(a_shift_below_cnt, clk_i, rst_ni, state_q == StShift, CntW'(j_q) < cnt_q)
  `MPA_ASSERT_IMP(a_scan_order, clk_i, rst_ni, state_q == StScan, CntW'(lo_q) <= CntW'(hi_q) + CntW'(1))
  `MPA_ASSERT_NXT(a_best_falls, clk_i, rst_ni, state_q == StScan && pend_q, best_q <= $past(best_q))
  `MPA_ASSERT_IMP(a_err_zero, clk_i, rst_ni, state_q == StResult && err_q, best_q == '0)

endmodule

### rtl/min_pair_average_after_sort_core.sv
// ----------------------------------------------------------------------------
// Minimum pair average core
// Collects a set of counts, pairs smallest with largest, and reports the
// least pair sum (the least pair average in half units).
// ----------------------------------------------------------------------------
// Counts arrive one request at a time; the request with last_item set closes
// the set and produces exactly one result request. Each count is placed in
// sorted order in a 256-entry RAM as it arrives. The first count of a set
// is written straight to the first entry. Any later count first fetches the
// top entry, then moves each larger stored count up one slot (the single RAM
// write port moves one entry per cycle) and then writes the count itself. A
// count that arrives while 256 are already stored is dropped. After the
// closing count, the pair scan reads both ends of the sorted run through the
// two read ports, one pair per cycle. A set of fewer than two counts, or one
// that had a count arriving while 256 were already stored, reports error = 1
// and a sum of 0 with no scan. The RAM needs no clearing pass: only entries
// written in the current set are used. The core holds its input off while it
// shifts or scans, and while a finished result waits for the output
// register; the output register holds one result, so the next set can start
// loading before the result is taken.
`timescale 1ns / 1ps

module min_pair_average_after_sort_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  mpa_in_if.sink     in_i,
  mpa_out_if.source  out_o
);

  logic                          mem_we;
  logic [mpa_pkg::AddrW-1:0]     mem_waddr;
  logic [mpa_pkg::CountW-1:0]    mem_wdata;
  logic [mpa_pkg::AddrW-1:0]     mem_raddr_a;
  logic [mpa_pkg::AddrW-1:0]     mem_raddr_b;
  logic [mpa_pkg::CountW-1:0]    mem_rdata_a;
  logic [mpa_pkg::CountW-1:0]    mem_rdata_b;
  mpa_pkg::res_t                 res;
  logic                          res_ready;

  logic                          out_valid_q;
  logic [mpa_pkg::SumW-1:0]      out_sum_q;
  logic                          out_err_q;

  // Sorted count store.
  mpa_ram #(
    .Depth (mpa_pkg::MaxItems),
    .Width (mpa_pkg::CountW)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

  // Insertion and pair scan sequencing.
  mpa_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_a_o (mem_raddr_a),
    .mem_raddr_b_o (mem_raddr_b),
    .mem_rdata_a_i (mem_rdata_a),
    .mem_rdata_b_i (mem_rdata_b),
    .res_o         (res),
    .res_ready_i   (res_ready)
  );

  // Take a new result when the output slot is empty or is being drained.
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res.valid;
    end
  end

  // Hold the payload until the result request is taken.
  always_ff @(posedge clk_i) begin
    if (res_ready && res.valid) begin
      out_sum_q <= res.sum;
      out_err_q <= res.error;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.min_average_halves = out_sum_q;
  assign out_o.error              = out_err_q;

endmodule
